/* design/dqsr_pkg.sv */
// Shared constants, codes and request/result types of the deque with search and removal.
package dqsr_pkg;

	localparam int DEPTH      = 16;
	localparam int ITEM_WIDTH = 32;
	localparam int AW         = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW         = $clog2(DEPTH + 1);

	typedef enum logic [3:0] {
		FN_PUSH_FRONT = 4'd0,
		FN_PUSH_BACK  = 4'd1,
		FN_POP_FRONT  = 4'd2,
		FN_POP_BACK   = 4'd3,
		FN_PEEK_FRONT = 4'd4,
		FN_PEEK_BACK  = 4'd5,
		FN_REMOVE     = 4'd6,
		FN_FIND       = 4'd7,
		FN_LIST       = 4'd8
	} func_t;

	typedef enum logic [1:0] {
		STAT_OK        = 2'd0,
		STAT_EMPTY     = 2'd1,
		STAT_FULL      = 2'd2,
		STAT_NOT_FOUND = 2'd3
	} status_t;

	typedef struct packed {
		func_t                  func;
		logic [ITEM_WIDTH-1:0]  item;
	} req_t;

	typedef struct packed {
		logic [ITEM_WIDTH-1:0]  result_data;
		logic                   found;
		logic [CW-1:0]          occupancy;
		status_t                status;
		logic                   last;
	} rsp_t;

endpackage

/* design/deque_with_search_and_removal.sv */
// Top level: deque kept in a synchronous memory, with search, removal and listing.
//
// Usage:
//   A request (req.func, req.item) is taken at a rising edge where start is high
//   and busy is low. Results appear on rsp for one cycle each, marked by
//   rsp_valid, and are taken at the edge that ends that cycle; the receiver has
//   no way to hold them off. Every request gives one result with rsp.last set,
//   except a list of a non-empty deque, which gives one result per entry, front
//   first, in consecutive cycles, the final one with rsp.last set.
// Sequencing:
//   push, undefined codes, and any request that finds the deque empty or full:
//     result in the cycle after the request, next request accepted at once.
//   pop and peek: one memory read into the read register, then the result.
//   find: entries read and compared from the front, one entry read per cycle.
//   remove: the search as for find, then each entry behind the match moves up
//     one place to close the gap (read next, write back), through the single memory.
//   list: results streamed one per cycle, front first.
// Reset clears the front pointer, the entry count and the control state; the
// entry memory is not cleared and only occupied slots ever reach a result.
module deque_with_search_and_removal (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  dqsr_pkg::req_t req,
	output dqsr_pkg::rsp_t rsp,
	output logic          rsp_valid
);
	import dqsr_pkg::*;

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_READ   = 5'b00010,
		ST_SEARCH = 5'b00100,
		ST_SHIFT  = 5'b01000,
		ST_LIST   = 5'b10000
	} state_t;

	logic [ITEM_WIDTH-1:0] mem [DEPTH];

	state_t                state_q;
	func_t                 func_q;
	logic [ITEM_WIDTH-1:0] key_q;
	logic [AW-1:0]         front_q;
	logic [CW-1:0]         count_q;
	logic [AW-1:0]         idx_q;
	logic [ITEM_WIDTH-1:0] rd_data_q;
	rsp_t                  rsp_q;
	logic                  rsp_valid_q;

	logic                  wr_en;
	logic [AW-1:0]         wr_addr;
	logic [ITEM_WIDTH-1:0] wr_data;
	logic [AW-1:0]         rd_addr;
	logic [AW-1:0]         front_dec;
	logic [AW-1:0]         front_inc;
	logic [AW-1:0]         last_pos;
	logic [AW-1:0]         idx_p1;
	logic [AW-1:0]         idx_p2;
	logic [CW-1:0]         idx_next;
	logic [CW-1:0]         count_m1;
	logic                  full;
	logic                  empty;
	logic                  hit;
	logic                  idx_last;

	// Map a position from the front to a memory slot
	function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] base,
		input logic [AW-1:0] pos);
		logic [AW:0] s;
		s = {1'b0, base} + {1'b0, pos};
		if (s >= (AW+1)'(DEPTH)) begin
			s = s - (AW+1)'(DEPTH);
		end
		return s[AW-1:0];
	endfunction

	// Build one result word
	function automatic rsp_t make_rsp(input logic [ITEM_WIDTH-1:0] data,
		input logic valid, input logic [CW-1:0] occ, input status_t st,
		input logic lst);
		rsp_t r;
		r.result_data = valid ? data : '0;
		r.found       = valid;
		r.occupancy   = occ;
		r.status      = st;
		r.last        = lst;
		return r;
	endfunction

	// Pointer arithmetic
	assign front_dec = (front_q == '0) ? AW'(DEPTH - 1) : front_q - AW'(1);
	assign front_inc = (front_q == AW'(DEPTH - 1)) ? '0 : front_q + AW'(1);
	assign count_m1  = count_q - CW'(1);
	assign last_pos  = count_m1[AW-1:0];
	assign idx_p1    = idx_q + AW'(1);
	assign idx_p2    = idx_q + AW'(2);
	assign idx_next  = CW'(idx_q) + CW'(1);
	assign idx_last  = (idx_next == count_q);
	assign full      = (count_q == CW'(DEPTH));
	assign empty     = (count_q == '0);
	assign hit       = (rd_data_q == key_q);

	// Memory port addressing
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = slot_of(front_q, count_q[AW-1:0]);
		wr_data = req.item;
		rd_addr = slot_of(front_q, idx_p1);
		unique case (state_q)
			ST_IDLE: begin
				case (req.func)
					FN_PUSH_FRONT: begin
						wr_en   = start && !full;
						wr_addr = front_dec;
					end
					FN_PUSH_BACK: begin
						wr_en   = start && !full;
					end
					FN_POP_BACK, FN_PEEK_BACK: begin
						rd_addr = slot_of(front_q, last_pos);
					end
					default: begin
						rd_addr = front_q;
					end
				endcase
			end
			ST_SHIFT: begin
				wr_en   = 1'b1;
				wr_addr = slot_of(front_q, idx_q);
				wr_data = rd_data_q;
				rd_addr = slot_of(front_q, idx_p2);
			end
			ST_READ, ST_SEARCH, ST_LIST: begin
				rd_addr = slot_of(front_q, idx_p1);
			end
			default: begin
				rd_addr = front_q;
			end
		endcase
	end

	// Entry memory: at most one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data_q <= mem[rd_addr];
	end

	// Request payload hold
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			func_q <= req.func;
			key_q  <= req.item;
		end
	end

	// Control sequencer and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			front_q     <= '0;
			count_q     <= '0;
			idx_q       <= '0;
			rsp_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			rsp_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					idx_q <= '0;
					if (start) begin
						case (req.func)
							FN_PUSH_FRONT, FN_PUSH_BACK: begin
								rsp_valid_q <= 1'b1;
								if (full) begin
									rsp_q <= make_rsp('0, 1'b0, count_q, STAT_FULL, 1'b1);
								end else begin
									if (req.func == FN_PUSH_FRONT) begin
										front_q <= front_dec;
									end
									count_q <= count_q + CW'(1);
									rsp_q   <= make_rsp('0, 1'b0, count_q + CW'(1),
										STAT_OK, 1'b1);
								end
							end
							FN_POP_FRONT, FN_POP_BACK, FN_PEEK_FRONT, FN_PEEK_BACK,
							FN_REMOVE, FN_FIND, FN_LIST: begin
								if (empty) begin
									rsp_valid_q <= 1'b1;
									rsp_q <= make_rsp('0, 1'b0, count_q, STAT_EMPTY, 1'b1);
								end else if (req.func == FN_REMOVE || req.func == FN_FIND) begin
									state_q <= ST_SEARCH;
								end else if (req.func == FN_LIST) begin
									state_q <= ST_LIST;
								end else begin
									state_q <= ST_READ;
								end
							end
							default: begin
								rsp_valid_q <= 1'b1;
								rsp_q <= make_rsp('0, 1'b0, count_q, STAT_OK, 1'b1);
							end
						endcase
					end
				end
				ST_READ: begin
					// Pop or peek at either end
					rsp_valid_q <= 1'b1;
					state_q     <= ST_IDLE;
					if (func_q == FN_POP_FRONT || func_q == FN_POP_BACK) begin
						count_q <= count_m1;
						rsp_q   <= make_rsp(rd_data_q, 1'b1, count_m1, STAT_OK, 1'b1);
						if (func_q == FN_POP_FRONT) begin
							front_q <= front_inc;
						end
					end else begin
						rsp_q <= make_rsp(rd_data_q, 1'b1, count_q, STAT_OK, 1'b1);
					end
				end
				ST_SEARCH: begin
					// Compare one entry per cycle from the front
					if (hit) begin
						rsp_valid_q <= 1'b1;
						if (func_q == FN_REMOVE) begin
							count_q <= count_m1;
							rsp_q   <= make_rsp(rd_data_q, 1'b1, count_m1, STAT_OK, 1'b1);
							state_q <= idx_last ? ST_IDLE : ST_SHIFT;
						end else begin
							rsp_q   <= make_rsp(rd_data_q, 1'b1, count_q, STAT_OK, 1'b1);
							state_q <= ST_IDLE;
						end
					end else if (idx_last) begin
						rsp_valid_q <= 1'b1;
						rsp_q   <= make_rsp('0, 1'b0, count_q, STAT_NOT_FOUND, 1'b1);
						state_q <= ST_IDLE;
					end else begin
						idx_q <= idx_p1;
					end
				end
				ST_SHIFT: begin
					// Move the next entry up one place; count already holds the new size
					if (idx_last) begin
						state_q <= ST_IDLE;
					end else begin
						idx_q <= idx_p1;
					end
				end
				ST_LIST: begin
					// Stream entries front to back
					rsp_valid_q <= 1'b1;
					rsp_q <= make_rsp(rd_data_q, 1'b1, count_q, STAT_OK, idx_last);
					if (idx_last) begin
						state_q <= ST_IDLE;
					end else begin
						idx_q <= idx_p1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign busy      = (state_q != ST_IDLE);
	assign rsp       = rsp_q;
	assign rsp_valid = rsp_valid_q;

endmodule

/* design/dqsr_checker.sv */
// Port-level checks of the deque with search and removal, bound to the top level.
module dqsr_checker (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           busy,
	input  dqsr_pkg::rsp_t rsp,
	input  logic           rsp_valid
);
	import dqsr_pkg::*;

	// A list run continues in the next cycle until its final result
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.last |=> rsp_valid)
		else $error("list run broken before its final result");

	// The block stays busy while a list run is still going
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.last |-> busy)
		else $error("idle in the middle of a list run");

	// Data is zero unless an entry is reported
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.found |-> rsp.result_data == '0)
		else $error("nonzero data without a found entry");

	// A full report comes only with a full deque
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status == STAT_FULL |-> rsp.occupancy == CW'(DEPTH) && !rsp.found)
		else $error("full status with occupancy below depth");

	// An empty report comes only with no entries
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status == STAT_EMPTY |-> rsp.occupancy == '0 && rsp.last)
		else $error("empty status with entries present");

endmodule

bind deque_with_search_and_removal dqsr_checker u_dqsr_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.busy      (busy),
	.rsp       (rsp),
	.rsp_valid (rsp_valid)
);

/* tb/testbench.sv */
// Testbench for the deque with search and removal: directed and random requests, checked results.
`timescale 1ns / 100ps

module testbench;
	import dqsr_pkg::*;

	// codes the block does not define; they must yield a plain ok result
	localparam logic [3:0] FN_UNUSED_LO = 4'd9;
	localparam logic [3:0] FN_UNUSED_HI = 4'd15;
	localparam int REQUEST_TARGET = 330;
	localparam int CALM_TAIL      = 60;
	localparam int QUIET_LIMIT    = 2000;
	localparam int TAIL_CYCLES    = 40;

	// Deque shadow: tracks contents on each accepted request and holds the results still due.
	class deque_tracker;
		logic [ITEM_WIDTH-1:0] slots [DEPTH];
		int unsigned head;
		int unsigned fill;
		rsp_t awaited [$];
		int errors;

		function new();
			head = 0;
			fill = 0;
			errors = 0;
		endfunction

		function logic [ITEM_WIDTH-1:0] entry_at(int unsigned pos);
			return slots[(head + pos) % DEPTH];
		endfunction

		function logic [ITEM_WIDTH-1:0] pick_key();
			if (fill == 0)
				return $urandom;
			return entry_at($urandom_range(0, fill - 1));
		endfunction

		function void post(logic [ITEM_WIDTH-1:0] data, bit valid, status_t st, bit fin);
			rsp_t e;
			e.result_data = valid ? data : '0;
			e.found       = valid;
			e.occupancy   = fill[CW-1:0];
			e.status      = st;
			e.last        = fin;
			awaited.push_back(e);
		endfunction

		// Advance the shadow by one request and queue the results it causes.
		function void note_request(req_t r);
			int unsigned pos;
			int unsigned i;
			logic [ITEM_WIDTH-1:0] v;
			case (r.func)
			FN_PUSH_FRONT, FN_PUSH_BACK: begin
				if (fill >= DEPTH) begin
					post('0, 1'b0, STAT_FULL, 1'b1);
				end else begin
					if (r.func == FN_PUSH_FRONT) begin
						head = (head + DEPTH - 1) % DEPTH;
						slots[head] = r.item;
					end else begin
						slots[(head + fill) % DEPTH] = r.item;
					end
					fill++;
					post('0, 1'b0, STAT_OK, 1'b1);
				end
			end
			FN_POP_FRONT, FN_POP_BACK, FN_PEEK_FRONT, FN_PEEK_BACK: begin
				if (fill == 0) begin
					post('0, 1'b0, STAT_EMPTY, 1'b1);
				end else begin
					pos = (r.func == FN_POP_FRONT || r.func == FN_PEEK_FRONT) ? 0 : fill - 1;
					v = entry_at(pos);
					if (r.func == FN_POP_FRONT) begin
						head = (head + 1) % DEPTH;
						fill--;
					end else if (r.func == FN_POP_BACK) begin
						fill--;
					end
					post(v, 1'b1, STAT_OK, 1'b1);
				end
			end
			FN_REMOVE, FN_FIND: begin
				if (fill == 0) begin
					post('0, 1'b0, STAT_EMPTY, 1'b1);
				end else begin
					pos = fill;
					for (i = 0; i < fill; i++)
						if (pos == fill && entry_at(i) == r.item)
							pos = i;
					if (pos == fill) begin
						post('0, 1'b0, STAT_NOT_FOUND, 1'b1);
					end else begin
						v = entry_at(pos);
						if (r.func == FN_REMOVE) begin
							// close the gap behind the match
							for (i = pos; i + 1 < fill; i++)
								slots[(head + i) % DEPTH] = entry_at(i + 1);
							fill--;
						end
						post(v, 1'b1, STAT_OK, 1'b1);
					end
				end
			end
			FN_LIST: begin
				if (fill == 0)
					post('0, 1'b0, STAT_EMPTY, 1'b1);
				else
					for (i = 0; i < fill; i++)
						post(entry_at(i), 1'b1, STAT_OK, i + 1 == fill);
			end
			default: begin
				post('0, 1'b0, STAT_OK, 1'b1);
			end
			endcase
		endfunction

		function void compare_field(string name, logic [ITEM_WIDTH-1:0] want,
				logic [ITEM_WIDTH-1:0] got);
			if (got !== want) begin
				$error("%s: expected %h, actual %h", name, want, got);
				errors++;
			end
		endfunction

		// Match a delivered result against the oldest one due.
		function void check_result(rsp_t got);
			rsp_t want;
			if (awaited.size() == 0) begin
				$error("result with nothing due: data %h status %0d", got.result_data, got.status);
				errors++;
				return;
			end
			want = awaited.pop_front();
			compare_field("result_data", want.result_data, got.result_data);
			compare_field("found", want.found, got.found);
			compare_field("occupancy", want.occupancy, got.occupancy);
			compare_field("status", want.status, got.status);
			compare_field("last", want.last, got.last);
		endfunction
	endclass

	logic   clk;
	logic   arst_n;
	logic   start;
	logic   busy;
	req_t   req;
	rsp_t   rsp;
	logic   rsp_valid;

	deque_tracker tracker = new();
	int sent;
	int idle_odds;
	int quiet;

	deque_with_search_and_removal u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.req       (req),
		.rsp       (rsp),
		.rsp_valid (rsp_valid)
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	// Note accepted requests before checking results of the same edge.
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy)
				tracker.note_request(req);
			if (rsp_valid)
				tracker.check_result(rsp);
		end
	end

	// Stop the run when nothing moves for too long.
	always @(posedge clk) begin
		if (arst_n && ((start && !busy) || rsp_valid))
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet >= QUIET_LIMIT) begin
			$display("testbench: done, errors");
			$finish;
		end
	end

	// Offer one request from a falling edge and hold it until taken; return at a falling edge.
	task automatic issue(input logic [3:0] code, input logic [ITEM_WIDTH-1:0] word);
		start = 1'b1;
		req.func = func_t'(code);
		req.item = word;
		do
			@(posedge clk);
		while (busy);
		sent++;
		@(negedge clk);
	endtask

	task automatic pause(input int n);
		start = 1'b0;
		repeat (n) @(negedge clk);
	endtask

	task automatic maybe_idle();
		if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1)
			pause($urandom_range(1, 11));
	endtask

	// Hold off new requests until every due result has arrived.
	task automatic drain();
		start = 1'b0;
		while (tracker.awaited.size() != 0)
			@(negedge clk);
	endtask

	function automatic logic [ITEM_WIDTH-1:0] rand_word();
		case ($urandom_range(0, 3))
		0: return $urandom_range(0, 7);
		1: return 32'hFFFF_FFFF - $urandom_range(0, 3);
		default: return $urandom;
		endcase
	endfunction

	function automatic logic [ITEM_WIDTH-1:0] rand_key();
		if ($urandom_range(0, 9) < 7)
			return tracker.pick_key();
		return rand_word();
	endfunction

	task automatic push_one();
		issue($urandom_range(0, 1) ? FN_PUSH_FRONT : FN_PUSH_BACK, rand_word());
		maybe_idle();
	endtask

	// One randomly weighted request against the current contents.
	task automatic mixed_one();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 35)
			issue($urandom_range(0, 1) ? FN_PUSH_FRONT : FN_PUSH_BACK, rand_word());
		else if (pick < 60)
			issue(4'($urandom_range(FN_POP_FRONT, FN_PEEK_BACK)), rand_word());
		else if (pick < 87)
			issue($urandom_range(0, 1) ? FN_REMOVE : FN_FIND, rand_key());
		else if (pick < 95)
			issue(FN_LIST, rand_word());
		else
			issue(4'($urandom_range(FN_UNUSED_LO, FN_UNUSED_HI)), rand_word());
		maybe_idle();
	endtask

	initial begin
		int kind;
		bit first;
		start = 1'b0;
		req = '0;
		arst_n = 1'b0;
		sent = 0;
		idle_odds = 0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// every lookup on an empty deque
		issue(FN_POP_FRONT, 32'h0);
		issue(FN_POP_BACK, 32'h0);
		issue(FN_PEEK_FRONT, 32'h0);
		issue(FN_PEEK_BACK, 32'h0);
		issue(FN_REMOVE, 32'h0);
		issue(FN_FIND, 32'h0);
		issue(FN_LIST, 32'h0);
		issue(FN_UNUSED_LO, 32'h0);
		issue(FN_UNUSED_HI, 32'hFFFF_FFFF);
		// build front: 5a5a5a5a ffffffff 00000000 a5a5a5a5
		issue(FN_PUSH_FRONT, 32'hFFFF_FFFF);
		issue(FN_PUSH_BACK, 32'h0);
		issue(FN_PUSH_FRONT, 32'h5A5A_5A5A);
		issue(FN_PUSH_BACK, 32'hA5A5_A5A5);
		issue(FN_FIND, 32'h1234_5678);
		issue(FN_REMOVE, 32'h1234_5678);
		issue(FN_FIND, 32'h0);
		issue(FN_LIST, 32'h0);
		issue(FN_REMOVE, 32'hFFFF_FFFF);
		issue(FN_PEEK_FRONT, 32'h0);
		issue(FN_PEEK_BACK, 32'h0);
		issue(FN_POP_FRONT, 32'h0);
		issue(FN_POP_BACK, 32'h0);
		issue(FN_REMOVE, 32'h0);
		issue(FN_LIST, 32'h0);
		drain();

		// random bursts; first one fills the deque to overflow
		first = 1'b1;
		while (sent < REQUEST_TARGET) begin
			idle_odds = (sent > REQUEST_TARGET - CALM_TAIL) ? 0 : $urandom_range(0, 4);
			kind = first ? 0 : $urandom_range(0, 6);
			first = 1'b0;
			case (kind)
			0: begin
				while (tracker.fill < DEPTH)
					push_one();
				repeat ($urandom_range(1, 2))
					push_one();
			end
			1: begin
				while (tracker.fill > 0) begin
					issue($urandom_range(0, 1) ? FN_POP_FRONT : FN_POP_BACK, rand_word());
					maybe_idle();
				end
				issue(4'($urandom_range(FN_POP_FRONT, FN_LIST)), rand_word());
				maybe_idle();
			end
			2: begin
				repeat (8) begin
					issue($urandom_range(0, 1) ? FN_REMOVE : FN_FIND, rand_key());
					maybe_idle();
				end
			end
			3: begin
				repeat ($urandom_range(1, 4))
					push_one();
				issue(FN_LIST, rand_word());
				maybe_idle();
			end
			default: begin
				repeat (10)
					mixed_one();
			end
			endcase
			if (idle_odds != 0 && $urandom_range(0, 7) == 0)
				drain();
		end

		drain();
		repeat (TAIL_CYCLES) @(negedge clk);
		if (tracker.errors == 0)
			$display("testbench: done, clean");
		else
			$display("testbench: done, errors");
		$finish;
	end

endmodule
